@@ hdl/slt_pkg.sv @@
// Package for the sorted list table: operation and status codes, field widths
// and the item and result structures shared by the controller and the top level.
// No dependencies.
package slt_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    localparam int TOTAL_W = 36;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_VAL   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
    localparam logic [OP_W-1:0] OP_MAKE_POS  = 3'd4;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
        logic [OP_W-1:0]           operation;
    } item_t;

    typedef struct packed {
        logic signed [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0]        count;
        logic                      found;
        logic [STAT_W-1:0]         status;
    } result_t;

endpackage

@@ hdl/slt_ram.sv @@
// Entry store of the sorted list table: one write port and one registered read port.
// Depends on nothing; the address width follows from DEPTH.
module slt_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic signed [31:0]  rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [31:0]  wr_data
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/slt_ctrl.sv @@
// Sequencer of the sorted list table: walks the entry store one entry per cycle,
// holds the entry count and running sum. Depends on slt_pkg and drives slt_ram.
module slt_ctrl #(
    parameter int DEPTH = slt_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  slt_pkg::item_t      in_item,
    output logic                res_valid,
    input  logic                res_ready,
    output slt_pkg::result_t    res,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  logic signed [31:0]  rd_data,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic signed [31:0]  wr_data
);

    import slt_pkg::*;

    localparam int PW = (CW > POS_W) ? CW : POS_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_CMP  = 4'd1;
    localparam logic [3:0] S_INS_LAST = 4'd2;
    localparam logic [3:0] S_DEL_CAP  = 4'd3;
    localparam logic [3:0] S_DEL_SH   = 4'd4;
    localparam logic [3:0] S_DV_CMP   = 4'd5;
    localparam logic [3:0] S_MP_WR    = 4'd6;
    localparam logic [3:0] S_SO_KEY   = 4'd7;
    localparam logic [3:0] S_SO_LD    = 4'd8;
    localparam logic [3:0] S_SR_RD    = 4'd9;
    localparam logic [3:0] S_SR_CMP   = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0]                state_reg, state_next;
    logic [OP_W-1:0]           op_reg, op_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [CW-1:0]             i_reg, i_next;
    logic [CW-1:0]             lo_reg, lo_next;
    logic [CW-1:0]             hi_reg, hi_next;
    logic [CW-1:0]             count_reg, count_next;
    logic signed [TOTAL_W-1:0] sum_reg, sum_next;
    logic [STAT_W-1:0]         status_reg, status_next;
    logic                      found_reg, found_next;

    logic [CW-1:0]             idx_p1;
    logic [CW-1:0]             idx_p2;
    logic [CW-1:0]             idx_m1;
    logic [CW-1:0]             idx_m2;
    logic [CW-1:0]             i_p1;
    logic [CW:0]               lo_hi_sum;
    logic [CW-1:0]             mid;
    logic signed [VALUE_W-1:0] abs_val;
    logic signed [TOTAL_W-1:0] rd_ext;
    logic signed [TOTAL_W-1:0] in_ext;
    logic signed [TOTAL_W-1:0] abs_ext;
    logic                      rd_gt_key;
    logic                      pos_ok;

    assign idx_p1    = idx_reg + CW'(1);
    assign idx_p2    = idx_reg + CW'(2);
    assign idx_m1    = idx_reg - CW'(1);
    assign idx_m2    = idx_reg - CW'(2);
    assign i_p1      = i_reg + CW'(1);
    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = lo_hi_sum[CW:1];
    assign rd_gt_key = rd_data > key_reg;
    assign pos_ok    = PW'(in_item.position) < PW'(count_reg);

    always_comb
    begin
        if (rd_data == 32'sh8000_0000)
        begin
            abs_val = 32'sh7FFF_FFFF;
        end
        else if (rd_data < 0)
        begin
            abs_val = -rd_data;
        end
        else
        begin
            abs_val = rd_data;
        end
    end

    assign rd_ext  = {{(TOTAL_W - VALUE_W){rd_data[VALUE_W-1]}}, rd_data};
    assign in_ext  = {{(TOTAL_W - VALUE_W){in_item.value[VALUE_W-1]}}, in_item.value};
    assign abs_ext = {{(TOTAL_W - VALUE_W){abs_val[VALUE_W-1]}}, abs_val};

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        i_next      = i_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        status_next = status_reg;
        found_next  = found_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = in_item.operation;
                    key_next    = in_item.value;
                    status_next = ST_DONE;
                    found_next  = 1'b0;
                    state_next  = S_DONE;
                    case (in_item.operation)
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                sum_next   = sum_reg + in_ext;
                                if (count_reg == '0)
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = '0;
                                    wr_data = in_item.value;
                                end
                                else
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = AW'(count_reg - CW'(1));
                                    idx_next   = count_reg;
                                    state_next = S_INS_CMP;
                                end
                            end
                        end
                        OP_DEL_AT:
                        begin
                            if (pos_ok)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(in_item.position);
                                idx_next   = CW'(in_item.position);
                                state_next = S_DEL_CAP;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        OP_DEL_VAL:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_DV_CMP;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            sum_next   = '0;
                        end
                        OP_MAKE_POS:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                sum_next   = '0;
                                state_next = S_MP_WR;
                            end
                        end
                        OP_SEARCH:
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = S_SR_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_INS_CMP:
            begin
                wr_en = 1'b1;
                if (rd_gt_key)
                begin
                    wr_data  = rd_data;
                    idx_next = idx_m1;
                    if (idx_reg == CW'(1))
                    begin
                        state_next = S_INS_LAST;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_m2[AW-1:0];
                    end
                end
                else
                begin
                    wr_data = key_reg;
                    if (op_reg == OP_MAKE_POS)
                    begin
                        i_next     = i_p1;
                        state_next = (i_p1 < count_reg) ? S_SO_KEY : S_DONE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_INS_LAST:
            begin
                wr_en   = 1'b1;
                wr_data = key_reg;
                if (op_reg == OP_MAKE_POS)
                begin
                    i_next     = i_p1;
                    state_next = (i_p1 < count_reg) ? S_SO_KEY : S_DONE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DEL_CAP, S_DV_CMP:
            begin
                if (state_reg == S_DEL_CAP || rd_data == key_reg)
                begin
                    count_next = count_reg - CW'(1);
                    sum_next   = sum_reg - rd_ext;
                    if (idx_p1 < count_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_p1[AW-1:0];
                        state_next = S_DEL_SH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (idx_p1 < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_p1[AW-1:0];
                    idx_next = idx_p1;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end

            S_DEL_SH:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                if (idx_p1 < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_p2[AW-1:0];
                    idx_next = idx_p1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_MP_WR:
            begin
                wr_en    = 1'b1;
                wr_data  = abs_val;
                sum_next = sum_reg + abs_ext;
                if (idx_p1 < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_p1[AW-1:0];
                    idx_next = idx_p1;
                end
                else if (count_reg > CW'(1))
                begin
                    i_next     = CW'(1);
                    state_next = S_SO_KEY;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SO_KEY:
            begin
                rd_en      = 1'b1;
                rd_addr    = i_reg[AW-1:0];
                state_next = S_SO_LD;
            end

            S_SO_LD:
            begin
                key_next   = rd_data;
                rd_en      = 1'b1;
                rd_addr    = AW'(i_reg - CW'(1));
                idx_next   = i_reg;
                state_next = S_INS_CMP;
            end

            S_SR_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid[AW-1:0];
                    idx_next   = mid;
                    state_next = S_SR_CMP;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end

            S_SR_CMP:
            begin
                if (rd_data == key_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (rd_gt_key)
                begin
                    hi_next    = idx_reg;
                    state_next = S_SR_RD;
                end
                else
                begin
                    lo_next    = idx_p1;
                    state_next = S_SR_RD;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_CLEAR;
            idx_reg    <= '0;
            i_reg      <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            status_reg <= ST_DONE;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            idx_reg    <= idx_next;
            i_reg      <= i_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign res.status = status_reg;
    assign res.found  = found_reg;
    assign res.count  = COUNT_W'(count_reg);
    assign res.total  = sum_reg;

endmodule

@@ hdl/sorted_list_table_core.sv @@
// Top level of the sorted list table: stream ports, output word register and checks.
// Depends on slt_pkg, slt_ctrl and slt_ram.
//
// The block keeps an ascending list of up to DEPTH signed 32-bit entries in a
// single-port-read RAM and answers every input word with one result word. Work
// is done one item at a time and its length is set by the RAM read port, which
// moves one entry per cycle: clear and ignored codes touch no entry, insert
// shifts each larger entry up by one, delete_at and delete_value shift the
// entries above the removed one down, delete_value first scans from the bottom
// for the match, search probes the list by bisection, and make_positive makes
// an absolute-value pass over all entries followed by an insertion sort.
// The entry RAM has no reset and needs no clearing pass.
// A result waits in the output register while the next input word is taken.
module sorted_list_table_core #(
    parameter int DEPTH = slt_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[35:32], zero[39:36]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], found[2], count[7:3], total[43:8], zero
);

    import slt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    item_t              item;
    result_t            res;
    result_t            out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic               res_valid;
    logic               res_ready;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    assign item.operation = s_tuser;
    assign item.value     = s_tdata[31:0];
    assign item.position  = s_tdata[35:32];

    slt_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    slt_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.total, out_reg.count, out_reg.found, out_reg.status};

`ifndef ASSERT_OFF
    a_no_result_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !res_valid)
        else $error("result pending while a new word is accepted");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("stalled result dropped by the sequencer");

    a_full_means_depth: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.status == ST_FULL |-> out_reg.count == COUNT_W'(DEPTH))
        else $error("full status with a count below depth");

    a_found_means_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.found |-> out_reg.status == ST_DONE)
        else $error("found flag with a failing status");
`endif

endmodule

@@ test/sorted_list_table_checker.sv @@
// Checker for the sorted list table: watches both stream channels, keeps its own copy
// of the list, predicts every result word and compares it field by field.
// Depends on slt_pkg.
module sorted_list_table_checker #(
    parameter int DEPTH = slt_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[35:32], zero[39:36]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // status[1:0], found[2], count[7:3], total[43:8], zero
    output int          mismatches,
    output int          outstanding,
    output int          results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    logic signed [VALUE_W-1:0] list_vals [DEPTH];
    int                        list_len;
    result_t                   expected_q [$];

    function automatic void remove_entry(int idx);
        int i;
        for (i = idx; i + 1 < list_len; i++)
            list_vals[i] = list_vals[i + 1];
        list_len--;
    endfunction

    function automatic result_t predict_word(logic [OP_W-1:0] op,
                                             logic signed [VALUE_W-1:0] val,
                                             logic [POS_W-1:0] pos);
        result_t                   r;
        int                        i;
        int                        k;
        int                        lo;
        int                        hi;
        int                        mid;
        logic signed [VALUE_W-1:0] key;
        logic signed [TOTAL_W-1:0] acc;
        r = '0;
        r.status = ST_DONE;
        case (op)
            OP_INSERT:
            begin
                if (list_len >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    k = 0;
                    while (k < list_len && list_vals[k] < val)
                        k++;
                    for (i = list_len; i > k; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[k] = val;
                    list_len++;
                end
            end
            OP_DEL_AT:
            begin
                if (int'(pos) < list_len)
                    remove_entry(int'(pos));
                else
                    r.status = ST_NOT_FOUND;
            end
            OP_DEL_VAL:
            begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < list_len; i++)
                begin
                    if (list_vals[i] == val)
                    begin
                        remove_entry(i);
                        r.status = ST_DONE;
                        break;
                    end
                end
            end
            OP_CLEAR:
                list_len = 0;
            OP_MAKE_POS:
            begin
                for (i = 0; i < list_len; i++)
                begin
                    if (list_vals[i] == 32'sh8000_0000)
                        list_vals[i] = 32'sh7FFF_FFFF;
                    else if (list_vals[i] < 0)
                        list_vals[i] = -list_vals[i];
                end
                for (i = 1; i < list_len; i++)
                begin
                    key = list_vals[i];
                    k = i;
                    while (k > 0 && list_vals[k - 1] > key)
                    begin
                        list_vals[k] = list_vals[k - 1];
                        k--;
                    end
                    list_vals[k] = key;
                end
            end
            OP_SEARCH:
            begin
                r.status = ST_NOT_FOUND;
                lo = 0;
                hi = list_len - 1;
                while (lo <= hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (list_vals[mid] == val)
                    begin
                        r.found = 1'b1;
                        r.status = ST_DONE;
                        break;
                    end
                    if (list_vals[mid] > val)
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
            end
            default:
            begin
            end
        endcase
        acc = '0;
        for (i = 0; i < list_len; i++)
            acc += list_vals[i];
        r.count = COUNT_W'(list_len);
        r.total = acc;
        return r;
    endfunction

    function automatic void note_mismatch(string field, logic signed [63:0] want,
                                          logic signed [63:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            list_len = 0;
            mismatches = 0;
            outstanding = 0;
            results_checked = 0;
            expected_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_word(s_tuser, s_tdata[31:0], s_tdata[35:32]));
            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[1:0];
                got.found  = m_tdata[2];
                got.count  = m_tdata[7:3];
                got.total  = m_tdata[43:8];
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with nothing expected, expected none, got %h",
                             $realtime, m_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (got.status !== want.status)
                        note_mismatch("status", want.status, got.status);
                    if (got.found !== want.found)
                        note_mismatch("found", want.found, got.found);
                    if (got.count !== want.count)
                        note_mismatch("count", want.count, got.count);
                    if (got.total !== want.total)
                        note_mismatch("total", $signed(want.total), $signed(got.total));
                end
            end
            outstanding = expected_q.size();
        end
    end

endmodule

@@ test/sorted_list_table_core_test.sv @@
// Testbench top for the sorted list table: clock, reset, directed and random words on
// the input stream, random stalls on the output stream and the final verdict.
// Depends on slt_pkg, sorted_list_table_core and sorted_list_table_checker.
module sorted_list_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam int RANDOM_WORDS = 1480;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    int mismatches;
    int outstanding;
    int results_checked;

    bit                 steady = 1'b0;
    int                 words_by_op [8];
    logic [VALUE_W-1:0] recent_vals [16];
    int                 recent_n = 0;

    always #2 clk = ~clk;

    sorted_list_table_core #(.DEPTH(DEPTH_DEF)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_list_table_checker #(.DEPTH(DEPTH_DEF)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int                 r;
        int                 s;
        logic [VALUE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            s = int'($urandom_range(0, 16)) - 8;
            return s;
        end
        else if (r < 60 && recent_n > 0)
        begin
            v = recent_vals[$urandom_range(0, (recent_n < 16 ? recent_n : 16) - 1)];
            return ($urandom_range(0, 3) == 0) ? -v : v;
        end
        else if (r < 70)
        begin
            case ($urandom_range(0, 5))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                3: return 32'h8000_0001;
                4: return 32'h0000_0001;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // Mode 0 mostly fills the list, mode 1 mostly drains it, mode 2 mixes evenly.
    function automatic logic [OP_W-1:0] pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return (r == 0) ? OP_SPARE_7 : OP_SPARE_6;
        if (r < 5)
            return OP_CLEAR;
        if (r < 9)
            return OP_MAKE_POS;
        case (mode)
            0:
            begin
                if (r < 70)
                    return OP_INSERT;
                if (r < 85)
                    return OP_SEARCH;
                return (r < 93) ? OP_DEL_VAL : OP_DEL_AT;
            end
            1:
            begin
                if (r < 28)
                    return OP_INSERT;
                if (r < 42)
                    return OP_SEARCH;
                return (r < 71) ? OP_DEL_VAL : OP_DEL_AT;
            end
            default:
            begin
                if (r < 48)
                    return OP_INSERT;
                if (r < 66)
                    return OP_SEARCH;
                return (r < 83) ? OP_DEL_VAL : OP_DEL_AT;
            end
        endcase
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        int gap;
        gap = steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, pos, val};
        do
            @(posedge clk);
        while (!s_tready);
        words_by_op[op]++;
        if (op == OP_INSERT)
        begin
            recent_vals[recent_n % 16] = val;
            recent_n++;
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = steady ? 0 : pick_gap();
            if (stall == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        int                 real_words;
        int                 mode;
        logic [OP_W-1:0]    op;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        send_word(OP_SEARCH, 32'h0000_0000, 4'd0);
        send_word(OP_DEL_AT, 32'h0000_0000, 4'd0);
        send_word(OP_DEL_VAL, 32'h0000_0007, 4'd0);
        send_word(OP_MAKE_POS, 32'h0000_0000, 4'd0);
        send_word(OP_CLEAR, 32'h0000_0000, 4'd0);
        send_word(OP_SPARE_6, 32'hFFFF_FFFF, 4'd15);
        send_word(OP_SPARE_7, 32'h5A5A_A5A5, 4'd10);
        send_word(OP_INSERT, 32'h7FFF_FFFF, 4'd15);
        send_word(OP_INSERT, 32'h8000_0000, 4'd5);
        send_word(OP_INSERT, 32'h0000_0000, 4'd0);
        send_word(OP_INSERT, 32'hFFFF_FFFF, 4'd10);
        send_word(OP_INSERT, 32'h0000_0000, 4'd3);
        send_word(OP_SPARE_6, 32'h0000_0000, 4'd0);
        send_word(OP_SEARCH, 32'h8000_0000, 4'd0);
        send_word(OP_SEARCH, 32'h0000_0005, 4'd0);
        send_word(OP_DEL_VAL, 32'hFFFF_FFFF, 4'd0);
        send_word(OP_DEL_AT, 32'h0000_0000, 4'd15);
        send_word(OP_MAKE_POS, 32'h0000_0000, 4'd0);
        send_word(OP_SEARCH, 32'h7FFF_FFFF, 4'd0);
        send_word(OP_DEL_AT, 32'h0000_0000, 4'd0);
        send_word(OP_CLEAR, 32'h0000_0000, 4'd0);

        real_words = 0;
        mode = 0;
        while (real_words < RANDOM_WORDS)
        begin
            if (real_words % 50 == 0)
                mode = $urandom_range(0, 2);
            if (real_words == 500 || real_words == 1000)
                drain_results();
            steady = (real_words >= 700 && real_words < 900);
            op = pick_op(mode);
            send_word(op, pick_value(), POS_W'($urandom_range(0, 15)));
            if (op != OP_SPARE_6 && op != OP_SPARE_7)
                real_words++;
        end
        drain_results();
        repeat (200) @(negedge clk);

        $display("Sent %0d inserts, %0d delete_at, %0d delete_value, %0d clears,",
                 words_by_op[OP_INSERT], words_by_op[OP_DEL_AT], words_by_op[OP_DEL_VAL],
                 words_by_op[OP_CLEAR]);
        $display("%0d make_positive, %0d searches, %0d spare codes; %0d results checked.",
                 words_by_op[OP_MAKE_POS], words_by_op[OP_SEARCH],
                 words_by_op[OP_SPARE_6] + words_by_op[OP_SPARE_7], results_checked);
        if (mismatches == 0)
            $display("sorted_list_table_core_test: done, clean");
        else
            $display("sorted_list_table_core_test: done, errors");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("Timeout with %0d results still expected.", outstanding);
        $display("sorted_list_table_core_test: done, errors");
        $finish;
    end

endmodule

@@ sorted_list_table_core.f @@
hdl/slt_pkg.sv
hdl/slt_ram.sv
hdl/slt_ctrl.sv
hdl/sorted_list_table_core.sv
test/sorted_list_table_checker.sv
test/sorted_list_table_core_test.sv
